// ----- rtl/core/ort_pkg.sv -----
// shared types, constants and helpers for the occupancy ray trace unit
package ort_pkg;

   localparam int GRID_WIDTH  = 512;
   localparam int GRID_HEIGHT = 512;
   localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W      = $clog2(GRID_DEPTH);

   localparam int COORD_W = 12;
   localparam int IDX_W   = COORD_W - 1;
   localparam int PROD_W  = 2 * IDX_W;
   localparam int VALUE_W = 12;
   localparam int SUM_W   = VALUE_W + 1;
   localparam int LIMIT_W = 11;
   localparam int COUNT_W = 13;
   localparam int ERR_W   = 15;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic signed [VALUE_W-1:0] HIT_INC_RESET  = 12'sd218;
   localparam logic signed [VALUE_W-1:0] MISS_INC_RESET = -12'sd102;
   localparam logic [LIMIT_W-1:0]        LIMIT_RESET    = 11'd1024;

   typedef enum logic {
      OP_TRACE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIT_INCREMENT  = 2'd0,
      CSR_MISS_INCREMENT = 2'd1,
      CSR_CLAMP_LIMIT    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] hit_inc;
      logic signed [VALUE_W-1:0] miss_inc;
      logic [LIMIT_W-1:0]        limit;
   } cfg_type;

   typedef struct packed {
      op_type                    op;
      logic signed [COORD_W-1:0] start_col;
      logic signed [COORD_W-1:0] start_row;
      logic signed [COORD_W-1:0] end_col;
      logic signed [COORD_W-1:0] end_row;
      logic                      hit;
      logic [COORD_W-1:0]        dcol;
      logic [COORD_W-1:0]        drow;
      logic                      col_neg;
      logic                      row_neg;
      logic [COUNT_W-1:0]        count;
   } task_type;

   function automatic logic in_grid(input logic [COORD_W-1:0] col,
                                    input logic [COORD_W-1:0] row);
      logic col_ok;
      logic row_ok;
      col_ok = !col[COORD_W-1] && ({1'b0, col} < (COORD_W+1)'(GRID_WIDTH));
      row_ok = !row[COORD_W-1] && ({1'b0, row} < (COORD_W+1)'(GRID_HEIGHT));
      return col_ok && row_ok;
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(row[IDX_W-1:0]) * PROD_W'(GRID_WIDTH) + PROD_W'(col[IDX_W-1:0]);
      return ADDR_W'(prod);
   endfunction

endpackage

// ----- rtl/core/ort_ram.sv -----
// generic simple dual port ram with registered read
module ort_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ort_front.sv -----
// request acceptance and ray classification ahead of the task queue
module ort_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ort_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   input  logic                             clear_done,
   input  logic                             queue_full,
   output logic                             push,
   output ort_pkg::task_type                push_task
);
   import ort_pkg::*;

   logic signed [COORD_W-1:0] c0, r0, c1, r1;
   logic signed [COORD_W:0]   dcol_diff, drow_diff;
   logic [COORD_W-1:0]        dcol, drow, span;

   assign c0 = req_tdata[COORD_W-1:0];
   assign r0 = req_tdata[2*COORD_W-1:COORD_W];
   assign c1 = req_tdata[3*COORD_W-1:2*COORD_W];
   assign r1 = req_tdata[4*COORD_W-1:3*COORD_W];

   assign req_tready = clear_done && !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      dcol_diff = (COORD_W+1)'(c1) - (COORD_W+1)'(c0);
      drow_diff = (COORD_W+1)'(r1) - (COORD_W+1)'(r0);
      dcol = dcol_diff[COORD_W] ? COORD_W'(-dcol_diff) : COORD_W'(dcol_diff);
      drow = drow_diff[COORD_W] ? COORD_W'(-drow_diff) : COORD_W'(drow_diff);
      span = (dcol > drow) ? dcol : drow;

      push_task.op        = op_type'(req_tuser);
      push_task.start_col = c0;
      push_task.start_row = r0;
      push_task.end_col   = c1;
      push_task.end_row   = r1;
      push_task.hit       = req_tdata[4*COORD_W];
      push_task.dcol      = dcol;
      push_task.drow      = drow;
      push_task.col_neg   = !(c0 < c1);
      push_task.row_neg   = !(r0 < r1);
      push_task.count     = COUNT_W'(span) + COUNT_W'(1);
   end

endmodule

// ----- rtl/core/ort_queue.sv -----
// short task queue between front and back
module ort_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ort_pkg::task_type push_task,
   output logic              full,
   output logic              task_valid,
   input  logic              pop,
   output ort_pkg::task_type pop_task
);
   import ort_pkg::*;

   task_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign task_valid = (count_ff != '0);
   assign pop_task   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule

// ----- rtl/core/ort_back.sv -----
// grid clearing, bresenham walker and cell read-modify-write pipeline
module ort_back (
   input  logic                               clock,
   input  logic                               reset,
   input  ort_pkg::cfg_type                   cfg,
   input  logic                               task_valid,
   input  ort_pkg::task_type                  cur_task,
   output logic                               task_pop,
   output logic                               clear_done,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic signed [ort_pkg::VALUE_W-1:0] rsp_cell_value,
   output logic [ort_pkg::COUNT_W-1:0]        rsp_cells_visited
);
   import ort_pkg::*;

   back_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic clear_last;

   // walker
   logic signed [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [COORD_W-1:0] end_col_ff, end_row_ff;
   logic                      col_neg_ff, row_neg_ff, hit_ff;
   logic signed [ERR_W-1:0]   dc_ff, dr_ff, err_ff, err_in;
   logic [COUNT_W-1:0]        count_ff;
   logic signed [ERR_W:0]     e2;
   logic                      at_end, walk_load, walk_step, start;

   // cell issue
   logic                      issue_valid, issue_read, issue_last;
   logic [COORD_W-1:0]        issue_col, issue_row;
   logic signed [VALUE_W-1:0] issue_inc;
   logic [COUNT_W-1:0]        issue_count;

   // read-modify-write stage
   logic                      s1_valid_ff, s1_we_ff, s1_read_ff, s1_last_ff, s1_in_grid_ff;
   logic [ADDR_W-1:0]         s1_addr_ff;
   logic signed [VALUE_W-1:0] s1_inc_ff;
   logic [COUNT_W-1:0]        s1_count_ff;
   logic signed [SUM_W-1:0]   sum, lim, neg_lim;
   logic signed [VALUE_W-1:0] clamped;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   // memory ports
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0]        ram_wr_data, ram_rd_data;

   assign clear_last = (clear_addr_ff == ADDR_W'(GRID_DEPTH - 1));
   assign clear_done = (state_ff != BACK_CLEAR);
   assign at_end     = (col_ff == end_col_ff) && (row_ff == end_row_ff);
   assign start      = task_valid && !s1_valid_ff && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            if (clear_last) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (start && cur_task.op == OP_TRACE) begin
               state_in = BACK_WALK;
            end
         end
         BACK_WALK: begin
            if (at_end) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      task_pop    = 1'b0;
      walk_load   = 1'b0;
      walk_step   = 1'b0;
      issue_valid = 1'b0;
      issue_read  = 1'b0;
      issue_last  = 1'b0;
      issue_col   = col_ff;
      issue_row   = row_ff;
      issue_inc   = cfg.miss_inc;
      issue_count = count_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
         end
         BACK_IDLE: begin
            task_pop = start;
            if (start && cur_task.op == OP_READ) begin
               issue_valid = 1'b1;
               issue_read  = 1'b1;
               issue_last  = 1'b1;
               issue_col   = cur_task.start_col;
               issue_row   = cur_task.start_row;
               issue_count = '0;
            end else if (start) begin
               walk_load = 1'b1;
            end
         end
         BACK_WALK: begin
            issue_valid = 1'b1;
            issue_last  = at_end;
            walk_step   = !at_end;
            if (at_end && hit_ff) begin
               issue_inc = cfg.hit_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // bresenham step
   always_comb begin
      e2     = {err_ff, 1'b0};
      err_in = err_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (e2 >= (ERR_W+1)'(dr_ff)) begin
         err_in = err_in + dr_ff;
         col_in = col_neg_ff ? col_ff - COORD_W'(1) : col_ff + COORD_W'(1);
      end
      if (e2 <= (ERR_W+1)'(dc_ff)) begin
         err_in = err_in + dc_ff;
         row_in = row_neg_ff ? row_ff - COORD_W'(1) : row_ff + COORD_W'(1);
      end
   end

   always_comb begin
      clear_addr_in = clear_last ? clear_addr_ff : clear_addr_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_CLEAR;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= issue_valid;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == BACK_CLEAR) begin
            clear_addr_ff <= clear_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (walk_load) begin
         col_ff     <= cur_task.start_col;
         row_ff     <= cur_task.start_row;
         end_col_ff <= cur_task.end_col;
         end_row_ff <= cur_task.end_row;
         col_neg_ff <= cur_task.col_neg;
         row_neg_ff <= cur_task.row_neg;
         hit_ff     <= cur_task.hit;
         dc_ff      <= ERR_W'(cur_task.dcol);
         dr_ff      <= -ERR_W'(cur_task.drow);
         err_ff     <= ERR_W'(cur_task.dcol) - ERR_W'(cur_task.drow);
         count_ff   <= cur_task.count;
      end else if (walk_step) begin
         col_ff <= col_in;
         row_ff <= row_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_valid) begin
         s1_in_grid_ff <= in_grid(issue_col, issue_row);
         s1_we_ff      <= !issue_read && in_grid(issue_col, issue_row);
         s1_read_ff    <= issue_read;
         s1_last_ff    <= issue_last;
         s1_addr_ff    <= cell_addr(issue_col, issue_row);
         s1_inc_ff     <= issue_inc;
         s1_count_ff   <= issue_count;
      end
   end

   // saturating update
   always_comb begin
      sum     = SUM_W'($signed(ram_rd_data)) + SUM_W'(s1_inc_ff);
      lim     = $signed(SUM_W'(cfg.limit));
      neg_lim = -lim;
      if (sum > lim) begin
         clamped = VALUE_W'(lim);
      end else if (sum < neg_lim) begin
         clamped = VALUE_W'(neg_lim);
      end else begin
         clamped = VALUE_W'(sum);
      end
   end

   assign ram_rd_addr = cell_addr(issue_col, issue_row);
   assign ram_we      = (state_ff == BACK_CLEAR) || (s1_valid_ff && s1_we_ff);
   assign ram_wr_addr = (state_ff == BACK_CLEAR) ? clear_addr_ff : s1_addr_ff;
   assign ram_wr_data = (state_ff == BACK_CLEAR) ? '0 : clamped;

   ort_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   always_comb begin
      if (s1_valid_ff && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_last_ff) begin
         rsp_value_ff <= (s1_read_ff && s1_in_grid_ff) ? $signed(ram_rd_data) : '0;
         rsp_count_ff <= s1_read_ff ? '0 : s1_count_ff;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_cells_visited = rsp_count_ff;

endmodule

// ----- rtl/core/occupancy_ray_trace_unit.sv -----
// Occupancy grid of saturating log-odds cells updated by Bresenham ray traces.
// After reset the grid memory is swept to zero, one cell a cycle, over all
// GRID_WIDTH * GRID_HEIGHT = 262144 cells; req_tready stays low during that
// pass while csr writes are taken as usual. A trace transaction walks one
// cell per cycle through the read-modify-write pipeline on the single grid
// memory, visiting max(|dcol|, |drow|) + 1 cells, and a read transaction
// looks one cell up; the next transaction starts once the pipeline drains.
// A short queue lets the next requests be accepted while a ray is being
// walked, and the response register lets a new ray start once a waiting
// response is taken.
module occupancy_ray_trace_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // start_col[11:0], start_row[23:12], end_col[35:24], end_row[47:36],
   // endpoint_hit[48], zero[55:49]
   input  logic [ort_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_value[11:0], cells_visited[24:12], zero[31:25]
   output logic [ort_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ort_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ort_pkg::CSR_DATA_W-1:0] csr_data
);
   import ort_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic     clear_done, queue_full, push, task_valid, task_pop;
   task_type push_task, pop_task;
   logic signed [VALUE_W-1:0] cell_value;
   logic [COUNT_W-1:0]        cells_visited;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HIT_INCREMENT:  cfg_in.hit_inc  = csr_data[VALUE_W-1:0];
            CSR_MISS_INCREMENT: cfg_in.miss_inc = csr_data[VALUE_W-1:0];
            CSR_CLAMP_LIMIT:    cfg_in.limit    = csr_data[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_inc  <= HIT_INC_RESET;
         cfg_ff.miss_inc <= MISS_INC_RESET;
         cfg_ff.limit    <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ort_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clear_done (clear_done),
      .queue_full (queue_full),
      .push       (push),
      .push_task  (push_task)
   );

   ort_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_task  (push_task),
      .full       (queue_full),
      .task_valid (task_valid),
      .pop        (task_pop),
      .pop_task   (pop_task)
   );

   ort_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .task_valid        (task_valid),
      .cur_task          (pop_task),
      .task_pop          (task_pop),
      .clear_done        (clear_done),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_cell_value    (cell_value),
      .rsp_cells_visited (cells_visited)
   );

   assign rsp_tdata = {(RSP_DATA_W - VALUE_W - COUNT_W)'(0), cells_visited, cell_value};

endmodule

// ----- test/occupancy_ray_trace_unit_test.sv -----
// self-checking testbench for the occupancy ray trace unit against a grid model
`timescale 1ns / 1ps

module occupancy_ray_trace_unit_test;
   import ort_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int SHOWN_MISMATCHES = 50;

   typedef struct {
      op_type                    op;
      logic signed [COORD_W-1:0] c0;
      logic signed [COORD_W-1:0] r0;
      logic signed [COORD_W-1:0] c1;
      logic signed [COORD_W-1:0] r1;
      logic                      hit;
      bit                        drain_first;
   } ray_item;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        walked;
   } cell_report;

   typedef struct {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } grid_setting;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = OP_TRACE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // grid model and its settings
   logic signed [VALUE_W-1:0] occ_grid [GRID_DEPTH];
   int hit_step = 218;
   int miss_step = -102;
   int sat_limit = 1024;

   ray_item ray_queue[$];
   ray_item ray_now;
   grid_setting setting_queue[$];
   grid_setting setting_now;
   cell_report awaited_cells[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int failures = 0;
   int requests_taken = 0;
   int responses_seen = 0;
   int writes_taken = 0;
   int long_rays = 0;
   int last_c = 10;
   int last_r = 10;
   longint budget = 0;
   longint cycle_count = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   occupancy_ray_trace_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic bit on_grid(int col, int row);
      return col >= 0 && col < GRID_WIDTH && row >= 0 && row < GRID_HEIGHT;
   endfunction

   function automatic void bump_cell(int col, int row, int inc);
      int sum;
      if (!on_grid(col, row)) return;
      sum = int'(occ_grid[row * GRID_WIDTH + col]) + inc;
      if (sum > sat_limit) sum = sat_limit;
      if (sum < -sat_limit) sum = -sat_limit;
      occ_grid[row * GRID_WIDTH + col] = VALUE_W'(sum);
   endfunction

   function automatic void apply_setting(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_HIT_INCREMENT: begin
            hit_step = int'($signed(data));
         end
         CSR_MISS_INCREMENT: begin
            miss_step = int'($signed(data));
         end
         CSR_CLAMP_LIMIT: begin
            sat_limit = int'(data[LIMIT_W-1:0]);
         end
         default: begin
         end
      endcase
   endfunction

   // walks the ray over the grid model, or looks one cell up
   function automatic cell_report update_grid(ray_item it);
      int col;
      int row;
      int c1;
      int r1;
      int dc;
      int dr;
      int sc;
      int sr;
      int err;
      int e2;
      int count;
      cell_report rep;
      rep.value = '0;
      rep.walked = '0;
      col = int'(it.c0);
      row = int'(it.r0);
      if (it.op == OP_READ) begin
         if (on_grid(col, row)) rep.value = occ_grid[row * GRID_WIDTH + col];
         return rep;
      end
      c1 = int'(it.c1);
      r1 = int'(it.r1);
      dc = (c1 > col) ? c1 - col : col - c1;
      dr = -((r1 > row) ? r1 - row : row - r1);
      sc = (col < c1) ? 1 : -1;
      sr = (row < r1) ? 1 : -1;
      err = dc + dr;
      count = 0;
      while (col != c1 || row != r1) begin
         e2 = 2 * err;
         bump_cell(col, row, miss_step);
         count++;
         if (e2 >= dr) begin
            err += dr;
            col += sc;
         end
         if (e2 <= dc) begin
            err += dc;
            row += sr;
         end
      end
      bump_cell(c1, r1, it.hit ? hit_step : miss_step);
      rep.walked = COUNT_W'(count + 1);
      return rep;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (failures < SHOWN_MISMATCHES)
         $display("mismatch at response %0d: %s got %0d want %0d",
                  responses_seen, what, got, want);
      failures++;
   endtask

   // driver: csr writes and request transactions
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (!csr_valid || csr_ready) begin
            if (csr_valid) begin
               apply_setting(setting_now.idx, setting_now.data);
               writes_taken++;
            end
            if (setting_queue.size() > 0) begin
               setting_now = setting_queue.pop_front();
               csr_valid <= 1'b1;
               csr_index <= setting_now.idx;
               csr_data <= setting_now.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) begin
               awaited_cells = {awaited_cells, update_grid(ray_now)};
               requests_taken++;
            end
            if (ray_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct &&
                !(ray_queue[0].drain_first && awaited_cells.size() != 0)) begin
               ray_now = ray_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({ray_now.hit, ray_now.r1, ray_now.c1,
                                         ray_now.r0, ray_now.c0});
               req_tuser <= ray_now.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: response transactions
   always @(posedge clock) begin
      cell_report want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_cells.size() == 0) begin
               report_mismatch("response with no request outstanding",
                               int'(rsp_tdata), 0);
            end else begin
               want = awaited_cells.pop_front();
               if (rsp_tdata[11:0] !== want.value)
                  report_mismatch("cell_value", int'($signed(rsp_tdata[11:0])),
                                  int'(want.value));
               if (rsp_tdata[24:12] !== want.walked)
                  report_mismatch("cells_visited", int'(rsp_tdata[24:12]),
                                  int'(want.walked));
            end
            responses_seen++;
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * (GRID_DEPTH + budget) + 100000) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] near(int centre, int spread);
      int v;
      v = centre + int'($urandom_range(2 * spread)) - spread;
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return COORD_W'(v);
   endfunction

   function automatic logic signed [COORD_W-1:0] any_coord();
      return COORD_W'($urandom_range(4095));
   endfunction

   task automatic queue_ray(input op_type op, input int c0, input int r0, input int c1,
                            input int r1, input logic hit, input bit drain_first);
      ray_item it;
      int span;
      it.op = op;
      it.c0 = COORD_W'(c0);
      it.r0 = COORD_W'(r0);
      it.c1 = COORD_W'(c1);
      it.r1 = COORD_W'(r1);
      it.hit = hit;
      it.drain_first = drain_first;
      span = 0;
      if (op == OP_TRACE) begin
         span = (c1 > c0) ? c1 - c0 : c0 - c1;
         if (r1 - r0 > span) span = r1 - r0;
         if (r0 - r1 > span) span = r0 - r1;
         if (span > 1000) long_rays++;
         last_c = c1;
         last_r = r1;
      end
      budget += span + 24;
      ray_queue = {ray_queue, it};
   endtask

   task automatic queue_random_rays(input int n);
      int hot_spots[3] = '{24, 256, 490};
      int sel;
      int kind;
      int c0;
      int r0;
      int c1;
      int r1;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         kind = $urandom_range(99);
         c0 = int'(near(hot_spots[$urandom_range(2)], 30));
         r0 = int'(near(hot_spots[$urandom_range(2)], 30));
         if (sel < 55) begin
            if (kind >= 80) begin
               c0 = int'(any_coord());
               r0 = int'(any_coord());
            end
            c1 = int'(near(c0, (kind < 75) ? 24 : 20));
            r1 = int'(near(r0, (kind < 75) ? 24 : 20));
            if (kind >= 75 && kind < 80) begin
               c1 = c0;
               r1 = r0;
            end
            if (kind >= 95) begin
               c1 = int'(any_coord());
               r1 = int'(any_coord());
            end
            queue_ray(OP_TRACE, c0, r0, c1, r1, 1'($urandom_range(1)),
                      $urandom_range(199) == 0);
         end else begin
            if (kind < 50) begin
               c0 = int'(near(last_c, 2));
               r0 = int'(near(last_r, 2));
            end else if (kind >= 85) begin
               c0 = int'(any_coord());
               r0 = int'(any_coord());
            end
            queue_ray(OP_READ, c0, r0, int'(any_coord()), int'(any_coord()),
                      1'($urandom_range(1)), $urandom_range(199) == 0);
         end
      end
   endtask

   task automatic queue_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] data);
      grid_setting s;
      s.idx = idx;
      s.data = data;
      setting_queue = {setting_queue, s};
      budget += 8;
   endtask

   initial begin
      int hit_set[5] = '{218, 2047, -1024, 0, 1024};
      int miss_set[5] = '{-102, -2048, 1024, 0, -1024};
      int limit_set[5] = '{1024, 2047, 0, 0, 1};
      int sender_set[5] = '{0, 49, 0, 28, 0};
      int receiver_set[5] = '{0, 0, 49, 28, 0};
      foreach (occ_grid[i]) occ_grid[i] = '0;
      hit_set[3] = int'($urandom_range(4095));
      miss_set[3] = int'($urandom_range(4095));
      limit_set[3] = int'($urandom_range(2047));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 5; p++) begin
         @(negedge clock);
         sender_idle_pct = sender_set[p];
         receiver_stall_pct = receiver_set[p];
         queue_setting(CSR_HIT_INCREMENT, CSR_DATA_W'(hit_set[p]));
         queue_setting(CSR_MISS_INCREMENT, CSR_DATA_W'(miss_set[p]));
         queue_setting(CSR_CLAMP_LIMIT, CSR_DATA_W'(limit_set[p]));
         if (p == 0) queue_setting(CSR_UNUSED, CSR_DATA_W'($urandom_range(4095)));
         while (setting_queue.size() > 0 || csr_valid) @(negedge clock);
         if (p == 0) begin
            queue_ray(OP_READ, 0, 0, 0, 0, 1'b0, 0);
            queue_ray(OP_TRACE, 10, 10, 10, 10, 1'b1, 0);
            queue_ray(OP_READ, 10, 10, 0, 0, 1'b0, 0);
            queue_ray(OP_TRACE, 0, 0, 20, 0, 1'b0, 0);
            queue_ray(OP_READ, 10, 0, 0, 0, 1'b0, 0);
            queue_ray(OP_READ, 20, 0, 0, 0, 1'b0, 0);
            queue_ray(OP_TRACE, 5, 5, 8, 30, 1'b1, 0);
            queue_ray(OP_TRACE, 100, 100, 90, 93, 1'b1, 0);
            queue_ray(OP_TRACE, -5, -3, 3, 4, 1'b1, 0);
            queue_ray(OP_READ, 3, 4, 0, 0, 1'b0, 0);
            queue_ray(OP_TRACE, -2048, -2048, 2047, 2047, 1'b1, 0);
            queue_ray(OP_READ, 300, 300, 0, 0, 1'b0, 0);
            queue_ray(OP_TRACE, 2047, -2048, -2048, 2047, 1'b0, 0);
            queue_ray(OP_TRACE, 511, 511, 511, 511, 1'b1, 0);
            queue_ray(OP_TRACE, 0, 511, 511, 0, 1'b0, 0);
            queue_ray(OP_TRACE, 600, -10, 700, 40, 1'b1, 0);
            queue_ray(OP_READ, 511, 511, 0, 0, 1'b0, 0);
            queue_ray(OP_READ, 512, 0, 0, 0, 1'b0, 0);
            queue_ray(OP_READ, 0, 512, 0, 0, 1'b0, 0);
            queue_ray(OP_READ, -1, 5, 0, 0, 1'b0, 0);
            queue_ray(OP_READ, -2048, 2047, 2047, -2048, 1'b1, 0);
            queue_ray(OP_READ, 2047, -2048, -2048, 2047, 1'b1, 0);
            // waits for every outstanding response before going on
            queue_ray(OP_TRACE, 10, 10, 10, 10, 1'b1, 1);
            queue_ray(OP_TRACE, 12, 40, 2, 38, 1'b0, 0);
            queue_ray(OP_READ, 10, 10, 0, 0, 1'b0, 0);
         end
         queue_random_rays(185);
         while (ray_queue.size() > 0 || req_tvalid || awaited_cells.size() > 0)
            @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
      end
      foreach (awaited_cells[i]) report_mismatch("response never arrived", 0, 1);
      $display("summary: %0d requests, %0d responses, %0d csr writes, %0d long rays",
               requests_taken, responses_seen, writes_taken, long_rays);
      $display("summary: five settings incl. saturation extremes, four idle patterns");
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
